// ===== hdl/tdsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tdsl_pkg
// Shared types, codes and lookup functions for the source lexer.
// ----------------------------------------------------------------------------
package tdsl_pkg;

  // Width of the running byte offset; token offsets are cut to 32 bits
  localparam int unsigned OFFSET_WIDTH = 32;

  // Scan states (0..5 are stored, 6..11 are transient outcomes)
  localparam logic [3:0] ST_IDENT       = 4'd0;
  localparam logic [3:0] ST_MINUS       = 4'd1;
  localparam logic [3:0] ST_NUMBER      = 4'd2;
  localparam logic [3:0] ST_OPER        = 4'd3;
  localparam logic [3:0] ST_COMMENT     = 4'd4;
  localparam logic [3:0] ST_START       = 4'd5;
  localparam logic [3:0] ST_DONE_IDENT  = 4'd6;
  localparam logic [3:0] ST_DONE_NUMBER = 4'd7;
  localparam logic [3:0] ST_DONE_OPER   = 4'd8;
  localparam logic [3:0] ST_EOF         = 4'd9;
  localparam logic [3:0] ST_ILLEGAL     = 4'd10;
  localparam logic [3:0] ST_PUNCT       = 4'd11;

  // Character classes
  localparam logic [3:0] CL_UNUSED  = 4'd0;
  localparam logic [3:0] CL_ALPHA   = 4'd1;
  localparam logic [3:0] CL_DIGIT   = 4'd2;
  localparam logic [3:0] CL_HASH    = 4'd3;
  localparam logic [3:0] CL_MINUS   = 4'd4;
  localparam logic [3:0] CL_NEWLINE = 4'd5;
  localparam logic [3:0] CL_NULL    = 4'd6;
  localparam logic [3:0] CL_OPER    = 4'd7;
  localparam logic [3:0] CL_PUNCT   = 4'd8;
  localparam logic [3:0] CL_SPACE   = 4'd9;

  // Token tags
  localparam logic [5:0] TK_ASSIGN    = 6'd0;
  localparam logic [5:0] TK_COMMA     = 6'd1;
  localparam logic [5:0] TK_DOT       = 6'd2;
  localparam logic [5:0] TK_COLON     = 6'd3;
  localparam logic [5:0] TK_SEMICOLON = 6'd4;
  localparam logic [5:0] TK_LBRACE    = 6'd5;
  localparam logic [5:0] TK_RBRACE    = 6'd6;
  localparam logic [5:0] TK_LBRACKET  = 6'd7;
  localparam logic [5:0] TK_RBRACKET  = 6'd8;
  localparam logic [5:0] TK_LPAREN    = 6'd9;
  localparam logic [5:0] TK_RPAREN    = 6'd10;
  localparam logic [5:0] TK_ADD       = 6'd11;
  localparam logic [5:0] TK_SUB       = 6'd12;
  localparam logic [5:0] TK_MUL       = 6'd13;
  localparam logic [5:0] TK_DIV       = 6'd14;
  localparam logic [5:0] TK_NEG       = 6'd15;
  localparam logic [5:0] TK_EQ        = 6'd16;
  localparam logic [5:0] TK_NE        = 6'd17;
  localparam logic [5:0] TK_GE        = 6'd18;
  localparam logic [5:0] TK_GT        = 6'd19;
  localparam logic [5:0] TK_LE        = 6'd20;
  localparam logic [5:0] TK_LT        = 6'd21;
  localparam logic [5:0] TK_KW_AND    = 6'd22;
  localparam logic [5:0] TK_KW_CASE   = 6'd23;
  localparam logic [5:0] TK_KW_DO     = 6'd24;
  localparam logic [5:0] TK_KW_ELIF   = 6'd25;
  localparam logic [5:0] TK_KW_ELSE   = 6'd26;
  localparam logic [5:0] TK_KW_END    = 6'd27;
  localparam logic [5:0] TK_KW_FOR    = 6'd28;
  localparam logic [5:0] TK_KW_FUN    = 6'd29;
  localparam logic [5:0] TK_KW_IF     = 6'd30;
  localparam logic [5:0] TK_KW_LET    = 6'd31;
  localparam logic [5:0] TK_KW_OR     = 6'd32;
  localparam logic [5:0] TK_KW_THEN   = 6'd33;
  localparam logic [5:0] TK_KW_WHILE  = 6'd34;
  localparam logic [5:0] TK_IDENT     = 6'd35;
  localparam logic [5:0] TK_NUMBER    = 6'd36;
  localparam logic [5:0] TK_EOF       = 6'd37;
  localparam logic [5:0] TK_ILLEGAL   = 6'd38;

  localparam logic [31:0] SPAN_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_stop;
    logic        last;
  } token_t;

  // Tokens produced by one byte: count is 0..2, tok0 goes out first
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_out_t;

  function automatic logic [3:0] char_class(input logic [7:0] b);
    logic [3:0] c;
    case (b) inside
      8'h00:                          c = CL_NULL;
      8'h09, 8'h20:                   c = CL_SPACE;
      8'h0A:                          c = CL_NEWLINE;
      "#":                            c = CL_HASH;
      "-":                            c = CL_MINUS;
      ["0":"9"]:                      c = CL_DIGIT;
      ["A":"Z"], ["a":"z"], "_":      c = CL_ALPHA;
      "(", ")", ",", ".", ":", ";",
      "[", "]", "{", "}":             c = CL_PUNCT;
      "!", "$", "%", "&", "*", "+", "/",
      "<", "=", ">", "?", "@", "^", "|", "~": c = CL_OPER;
      default:                        c = CL_UNUSED;
    endcase
    return c;
  endfunction

  // Transition table of the scanner
  function automatic logic [3:0] next_state(input logic [3:0] s, input logic [3:0] cls);
    logic [3:0] n;
    unique case (s)
      ST_IDENT:
        n = (cls == CL_ALPHA || cls == CL_DIGIT) ? ST_IDENT : ST_DONE_IDENT;
      ST_MINUS:
        n = (cls == CL_DIGIT) ? ST_NUMBER :
            (cls == CL_MINUS || cls == CL_OPER) ? ST_OPER : ST_DONE_OPER;
      ST_NUMBER:
        n = (cls == CL_DIGIT) ? ST_NUMBER : ST_DONE_NUMBER;
      ST_OPER:
        n = (cls == CL_MINUS || cls == CL_OPER) ? ST_OPER : ST_DONE_OPER;
      ST_COMMENT:
        n = (cls == CL_NEWLINE) ? ST_START :
            (cls == CL_NULL) ? ST_EOF : ST_COMMENT;
      default: begin
        case (cls)
          CL_ALPHA:            n = ST_IDENT;
          CL_DIGIT:            n = ST_NUMBER;
          CL_HASH:             n = ST_COMMENT;
          CL_MINUS:            n = ST_MINUS;
          CL_NULL:             n = ST_EOF;
          CL_OPER:             n = ST_OPER;
          CL_PUNCT:            n = ST_PUNCT;
          CL_NEWLINE, CL_SPACE: n = ST_START;
          default:             n = ST_ILLEGAL;
        endcase
      end
    endcase
    return n;
  endfunction

  // Identifier or keyword; head byte i sits at bits 8i+7..8i
  function automatic logic [5:0] ident_tag(input logic [39:0] head, input logic [31:0] span);
    logic [15:0] w2;
    logic [23:0] w3;
    logic [31:0] w4;
    logic [39:0] w5;
    logic [5:0]  t;
    w2 = {head[7:0], head[15:8]};
    w3 = {w2, head[23:16]};
    w4 = {w3, head[31:24]};
    w5 = {w4, head[39:32]};
    t  = TK_IDENT;
    if (span == 32'd2) begin
      if (w2 == "do") t = TK_KW_DO;
      else if (w2 == "if") t = TK_KW_IF;
      else if (w2 == "or") t = TK_KW_OR;
    end else if (span == 32'd3) begin
      if (w3 == "and") t = TK_KW_AND;
      else if (w3 == "end") t = TK_KW_END;
      else if (w3 == "for") t = TK_KW_FOR;
      else if (w3 == "fun") t = TK_KW_FUN;
      else if (w3 == "let") t = TK_KW_LET;
    end else if (span == 32'd4) begin
      if (w4 == "case") t = TK_KW_CASE;
      else if (w4 == "elif") t = TK_KW_ELIF;
      else if (w4 == "else") t = TK_KW_ELSE;
      else if (w4 == "then") t = TK_KW_THEN;
    end else if (span == 32'd5) begin
      if (w5 == "while") t = TK_KW_WHILE;
    end
    return t;
  endfunction

  // Operator span: single operators and the two-byte comparisons
  function automatic logic [5:0] oper_tag(input logic [39:0] head, input logic [31:0] span);
    logic [5:0] t;
    t = TK_ILLEGAL;
    if (span == 32'd1) begin
      case (head[7:0])
        "=":     t = TK_ASSIGN;
        "+":     t = TK_ADD;
        "-":     t = TK_SUB;
        "*":     t = TK_MUL;
        "/":     t = TK_DIV;
        "~":     t = TK_NEG;
        ">":     t = TK_GT;
        "<":     t = TK_LT;
        default: t = TK_ILLEGAL;
      endcase
    end else if (span == 32'd2 && head[15:8] == "=") begin
      case (head[7:0])
        "=":     t = TK_EQ;
        "!":     t = TK_NE;
        ">":     t = TK_GE;
        "<":     t = TK_LE;
        default: t = TK_ILLEGAL;
      endcase
    end
    return t;
  endfunction

  function automatic logic [5:0] punct_tag(input logic [7:0] b);
    logic [5:0] t;
    case (b)
      ",":     t = TK_COMMA;
      ".":     t = TK_DOT;
      ":":     t = TK_COLON;
      ";":     t = TK_SEMICOLON;
      "{":     t = TK_LBRACE;
      "}":     t = TK_RBRACE;
      "[":     t = TK_LBRACKET;
      "]":     t = TK_RBRACKET;
      "(":     t = TK_LPAREN;
      ")":     t = TK_RPAREN;
      default: t = TK_ILLEGAL;
    endcase
    return t;
  endfunction

  // Offset cut to the 32-bit port width
  function automatic logic [31:0] off_out(input logic [OFFSET_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

// ===== hdl/tdsl_if.sv =====
// ----------------------------------------------------------------------------
// tdsl_byte_if / tdsl_token_if
// Valid/ready channels for source bytes and tokens.
// ----------------------------------------------------------------------------
interface tdsl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tdsl_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] token_start;
  logic [31:0] token_stop;
  logic        last;

  modport source (output valid, output token_kind, output token_start,
                  output token_stop, output last, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_stop, input last, output ready);
endinterface

// ===== hdl/tdsl_core.sv =====
// ----------------------------------------------------------------------------
// tdsl_core
// Scanner state and token forming for one byte per step.
// ----------------------------------------------------------------------------
module tdsl_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           in_byte,
  output tdsl_pkg::step_out_t  res
);
  import tdsl_pkg::*;

  logic [2:0]              scan_state, scan_state_next;
  logic [31:0]             span_count, span_count_next;
  logic [39:0]             head_chars, head_chars_next;
  logic [OFFSET_WIDTH-1:0] byte_offset, byte_offset_next;

  logic [3:0]  cls, cur, ns, ns2;
  logic        first_fire, second_fire;
  logic [5:0]  tag1, tag2;
  logic [63:0] start_wide;
  logic [31:0] span_eff;
  logic [39:0] head_eff;
  token_t      t1, t2;

  // Classify and take the table step, then rescan from start on a span end
  always_comb begin
    cls        = char_class(in_byte);
    cur        = (scan_state > ST_START[2:0]) ? ST_START : {1'b0, scan_state};
    ns         = next_state(cur, cls);
    first_fire = (ns == ST_DONE_IDENT) || (ns == ST_DONE_NUMBER) || (ns == ST_DONE_OPER);
    ns2        = first_fire ? next_state(ST_START, cls) : ns;
    second_fire = (ns2 == ST_EOF) || (ns2 == ST_ILLEGAL) || (ns2 == ST_PUNCT);

    if (ns == ST_DONE_IDENT)       tag1 = ident_tag(head_chars, span_count);
    else if (ns == ST_DONE_NUMBER) tag1 = TK_NUMBER;
    else                           tag1 = oper_tag(head_chars, span_count);

    if (ns2 == ST_EOF)        tag2 = TK_EOF;
    else if (ns2 == ST_PUNCT) tag2 = punct_tag(in_byte);
    else                      tag2 = TK_ILLEGAL;

    start_wide = 64'(byte_offset) - 64'(span_count);
    t1.token_kind  = tag1;
    t1.token_start = off_out(start_wide[OFFSET_WIDTH-1:0]);
    t1.token_stop  = off_out(byte_offset);
    t1.last        = !second_fire;

    t2.token_kind  = tag2;
    t2.token_start = off_out(byte_offset);
    t2.token_stop  = (ns2 == ST_EOF) ? off_out(byte_offset)
                                     : off_out(byte_offset + OFFSET_WIDTH'(1));
    t2.last        = 1'b1;

    res.count = 2'(first_fire) + 2'(second_fire);
    res.tok0  = first_fire ? t1 : t2;
    res.tok1  = t2;
  end

  // Next scanner state
  always_comb begin
    span_eff = first_fire ? '0 : span_count;
    head_eff = first_fire ? '0 : head_chars;
    scan_state_next  = scan_state;
    span_count_next  = span_eff;
    head_chars_next  = head_eff;
    byte_offset_next = byte_offset + OFFSET_WIDTH'(1);
    if (ns2 == ST_EOF) begin
      scan_state_next  = ST_START[2:0];
      span_count_next  = '0;
      head_chars_next  = '0;
      byte_offset_next = '0;
    end else if (ns2 == ST_ILLEGAL || ns2 == ST_PUNCT) begin
      scan_state_next = ST_START[2:0];
    end else begin
      if (ns2 <= ST_OPER) begin
        case (span_eff)
          32'd0:   head_chars_next[7:0]   = head_eff[7:0]   | in_byte;
          32'd1:   head_chars_next[15:8]  = head_eff[15:8]  | in_byte;
          32'd2:   head_chars_next[23:16] = head_eff[23:16] | in_byte;
          32'd3:   head_chars_next[31:24] = head_eff[31:24] | in_byte;
          32'd4:   head_chars_next[39:32] = head_eff[39:32] | in_byte;
          default: head_chars_next = head_eff;
        endcase
        if (span_eff != SPAN_MAX) span_count_next = span_eff + 32'd1;
      end
      scan_state_next = ns2[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state  <= ST_START[2:0];
      span_count  <= '0;
      head_chars  <= '0;
      byte_offset <= '0;
    end else if (step) begin
      scan_state  <= scan_state_next;
      span_count  <= span_count_next;
      head_chars  <= head_chars_next;
      byte_offset <= byte_offset_next;
    end
  end

  // End of text always restarts offsets
  a_eof_offset: assert property (@(posedge clk) disable iff (rst)
    step && ns2 == ST_EOF |=> byte_offset == '0)
    else $error("offset not cleared after end of text");

  // With two tokens only the second carries last
  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    step && res.count == 2'd2 |-> res.tok1.last && !res.tok0.last)
    else $error("last flag misplaced on token pair");

  // A comment byte leaves the span empty
  a_comment_span: assert property (@(posedge clk) disable iff (rst)
    step && scan_state_next == ST_COMMENT[2:0] |=> span_count == '0)
    else $error("span open inside comment");

endmodule

// ===== hdl/tdsl_out_queue.sv =====
// ----------------------------------------------------------------------------
// tdsl_out_queue
// Four-entry token queue: takes up to two tokens, sends one per cycle while tok.ready is high.
// ----------------------------------------------------------------------------
module tdsl_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  tdsl_pkg::step_out_t push,
  output logic                room,
  tdsl_token_if.source        tok
);
  import tdsl_pkg::*;

  token_t     entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic [1:0] push_cnt;
  logic       pop;

  assign push_cnt = push_en ? push.count : 2'd0;
  assign pop      = tok.valid && tok.ready;
  assign room     = (count <= 3'd2);

  assign count_next = count + 3'(push_cnt) - 3'(pop);

  // Output side reads the head entry
  assign tok.valid       = (count != 3'd0);
  assign tok.token_kind  = entries[rd_ptr].token_kind;
  assign tok.token_start = entries[rd_ptr].token_start;
  assign tok.token_stop  = entries[rd_ptr].token_stop;
  assign tok.last        = entries[rd_ptr].last;

  // Storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) entries[wr_ptr] <= push.tok0;
    if (push_cnt == 2'd2) entries[wr_ptr + 2'd1] <= push.tok1;
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_cnt != 2'd0 |-> room)
    else $error("token push without room");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("token queue fill out of range");

  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    count == 3'd0 && push_cnt == 2'd0 |=> !tok.valid)
    else $error("token shown from empty queue");

endmodule

// ===== hdl/table_driven_source_lexer_top.sv =====
// ----------------------------------------------------------------------------
// table_driven_source_lexer_top
// Byte-serial table-driven lexer producing tagged tokens with offsets.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one source byte per item (in_byte); a zero byte ends the
//   text. tok carries tokens: kind tag, start offset, stop offset, and last,
//   which is set on the final token caused by a byte. A byte gives zero,
//   one or two tokens.
// Timing:
//   A byte is held in an input register, then the scanner logic writes its
//   tokens into a four-entry output queue. The first token of a byte passes
//   through the input register and the queue before it is shown and can
//   leave. Throughput is one byte per cycle while the queue holds at most
//   two tokens; output drains one token per cycle while tok.ready is high,
//   so a byte that gives two tokens sends them out one after the other.
// Reset:
//   rst (synchronous) returns the scanner to start, clears the span and
//   offset, and empties the queue and input register.
// Stalls:
//   When tok.ready is low, tokens stay in the queue; once fewer than two
//   entries are free the input register stops advancing and src.ready
//   drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module table_driven_source_lexer_top (
  input  logic         clk,
  input  logic         rst,
  tdsl_byte_if.sink    src,
  tdsl_token_if.source tok
);
  import tdsl_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       room;
  logic       advance;
  step_out_t  res;

  assign advance   = stage_valid && room;
  assign src.ready = !stage_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src.ready) begin
      stage_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) stage_byte <= src.in_byte;
  end

  tdsl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (stage_byte),
    .res     (res)
  );

  tdsl_out_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_en (advance),
    .push    (res),
    .room    (room),
    .tok     (tok)
  );

endmodule
